[hdl/md5_pkg.sv]
// MD5 package: payload structs, sequencer states, round tables and helpers.
// No dependencies; used by every module of md5_message_digest.
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  // working variables of one compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_abcd_t;

  // write controls for the block buffer
  typedef struct packed {
    logic        byte_en;
    logic [5:0]  byte_pos;
    logic [7:0]  byte_val;
    logic        len_en;
    logic [63:0] len;
  } md5_bufwr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } md5_state_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // message word used in round r
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0:    g = r[3:0];
      2'd1:    g = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2:    g = 4'(r[3:0] * 4'd3 + 4'd5);
      default: g = 4'(r[3:0] * 4'd7);
    endcase
    return g;
  endfunction

endpackage

[hdl/md5_round.sv]
// MD5 round unit: one round step of the compression, shared over all 64 rounds.
// Depends on md5_pkg for the working-variable struct and round tables.
module md5_round import md5_pkg::*; (
  input  md5_abcd_t   cur,
  input  logic [31:0] msg_word,
  input  logic [5:0]  round,
  output md5_abcd_t   nxt
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_w;

  always_comb begin
    case (round[5:4])
      2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1:    f = (cur.b & cur.d) | (cur.c & ~cur.d);
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      default: f = cur.c ^ (cur.b | ~cur.d);
    endcase
  end

  assign sum   = cur.a + f + round_k(round) + msg_word;
  assign rot_w = {sum, sum} << round_s(round);

  assign nxt.a = cur.d;
  assign nxt.b = cur.b + rot_w[63:32];
  assign nxt.c = cur.b;
  assign nxt.d = cur.c;

endmodule

[hdl/md5_blkbuf.sv]
// MD5 block buffer: sixteen 32-bit message words, byte writes, length-word writes.
// Depends on md5_pkg for the write-control struct.
module md5_blkbuf import md5_pkg::*; (
  input  logic        clk,
  input  md5_bufwr_t  wr,
  input  logic [3:0]  rd_idx,
  output logic [31:0] rd_word
);

  logic [31:0] words_r [16];

  // little-endian byte packing; length words go to the last two slots
  always_ff @(posedge clk) begin
    if (wr.byte_en) begin
      words_r[wr.byte_pos[5:2]][8*wr.byte_pos[1:0] +: 8] <= wr.byte_val;
    end
    if (wr.len_en) begin
      words_r[14] <= wr.len[31:0];
      words_r[15] <= wr.len[63:32];
    end
  end

  assign rd_word = words_r[rd_idx];

endmodule

[hdl/md5_message_digest.sv]
// MD5 message digest top level: sequencer, chaining words, length counter.
// Depends on md5_pkg, md5_blkbuf and md5_round.
//
//   channel  ports                          moves
//   input    in_valid  in_ready  in_data    one item: byte, has_byte, end flag
//   output   out_valid out_ready out_data   one digest word, four per message
//
// Sequence: the item that fills byte 64 starts a compression (64 rounds through
// the single round unit plus the chaining add). An end item adds pad bytes up to
// byte 56 (or 64 and then 56 when the block has more than 55 bytes), the length
// words, a compression per padded block and four output items. rst_n is
// synchronous and loads the initial chaining words. in_ready is low from the
// item that starts work until its compression ends or, for an end item, until
// the last digest word is taken; a stalled out_ready holds the current word.
module md5_message_digest import md5_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  md5_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output md5_out_t out_data
);

  md5_state_t  state_r, state_nxt;
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  md5_abcd_t   abcd_r, abcd_nxt, round_out;
  logic [5:0]  round_r, round_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic        pend_end_r, pend_end_nxt;   // end seen with the block-filling byte
  logic        mark_done_r, mark_done_nxt; // 0x80 already written
  logic        final_blk_r, final_blk_nxt; // running compression is the last one
  logic [1:0]  oidx_r, oidx_nxt;
  md5_bufwr_t  bufwr;
  logic [31:0] msg_word;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  md5_blkbuf u_buf (
    .clk     (clk),
    .wr      (bufwr),
    .rd_idx  (msg_index(round_r)),
    .rd_word (msg_word)
  );

  md5_round u_round (
    .cur      (abcd_r),
    .msg_word (msg_word),
    .round    (round_r),
    .nxt      (round_out)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.has_byte && pos_r == 6'd63) begin
            state_nxt = ST_ROUND;
          end else if (in_data.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (round_r == 6'd63) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (final_blk_r) begin
          state_nxt = ST_OUT;
        end else if (pend_end_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (pos_r == 6'd55) begin
          state_nxt = ST_LEN;
        end else if (pos_r == 6'd63) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_LEN: state_nxt = ST_ROUND;
      ST_OUT: begin
        if (out_acc && oidx_r == 2'd3) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    out_valid     = (state_r == ST_OUT);
    out_data.digest_word = chain_r[oidx_r];
    out_data.word_index  = oidx_r;
    out_data.last_word   = (oidx_r == 2'd3);

    chain_nxt     = chain_r;
    abcd_nxt      = abcd_r;
    round_nxt     = round_r;
    pos_nxt       = pos_r;
    bitlen_nxt    = bitlen_r;
    pend_end_nxt  = pend_end_r;
    mark_done_nxt = mark_done_r;
    final_blk_nxt = final_blk_r;
    oidx_nxt      = oidx_r;

    bufwr.byte_en  = 1'b0;
    bufwr.byte_pos = pos_r;
    bufwr.byte_val = in_data.data_byte;
    bufwr.len_en   = 1'b0;
    bufwr.len      = bitlen_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // absorb the byte first, padding follows
          if (in_data.has_byte) begin
            bufwr.byte_en = 1'b1;
            pos_nxt       = pos_r + 6'd1;
            bitlen_nxt    = bitlen_r + 64'd8;
          end
          pend_end_nxt = in_data.end_of_message;
        end
      end
      ST_ROUND: begin
        abcd_nxt  = round_out;
        round_nxt = round_r + 6'd1;
      end
      ST_FINAL: begin
        chain_nxt[0] = chain_r[0] + abcd_r.a;
        chain_nxt[1] = chain_r[1] + abcd_r.b;
        chain_nxt[2] = chain_r[2] + abcd_r.c;
        chain_nxt[3] = chain_r[3] + abcd_r.d;
        oidx_nxt     = 2'd0;
      end
      ST_PAD: begin
        // marker once, then zero fill up to the length field
        bufwr.byte_en  = 1'b1;
        bufwr.byte_val = mark_done_r ? 8'h00 : PAD_MARK;
        mark_done_nxt  = 1'b1;
        pos_nxt        = pos_r + 6'd1;
      end
      ST_LEN: begin
        bufwr.len_en  = 1'b1;
        final_blk_nxt = 1'b1;
      end
      ST_OUT: begin
        if (out_acc) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            // restart for the next message
            chain_nxt[0]  = IV0;
            chain_nxt[1]  = IV1;
            chain_nxt[2]  = IV2;
            chain_nxt[3]  = IV3;
            pos_nxt       = 6'd0;
            bitlen_nxt    = 64'd0;
            pend_end_nxt  = 1'b0;
            mark_done_nxt = 1'b0;
            final_blk_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // load the working variables on entry to a compression
    if (state_nxt == ST_ROUND && state_r != ST_ROUND) begin
      abcd_nxt.a = chain_r[0];
      abcd_nxt.b = chain_r[1];
      abcd_nxt.c = chain_r[2];
      abcd_nxt.d = chain_r[3];
      round_nxt  = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chain_r[0]  <= IV0;
      chain_r[1]  <= IV1;
      chain_r[2]  <= IV2;
      chain_r[3]  <= IV3;
      round_r     <= 6'd0;
      pos_r       <= 6'd0;
      bitlen_r    <= 64'd0;
      pend_end_r  <= 1'b0;
      mark_done_r <= 1'b0;
      final_blk_r <= 1'b0;
      oidx_r      <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      round_r     <= round_nxt;
      pos_r       <= pos_nxt;
      bitlen_r    <= bitlen_nxt;
      pend_end_r  <= pend_end_nxt;
      mark_done_r <= mark_done_nxt;
      final_blk_r <= final_blk_nxt;
      oidx_r      <= oidx_nxt;
    end
  end

  // working variables carry no reset
  always_ff @(posedge clk) begin
    abcd_r <= abcd_nxt;
  end

endmodule

[bench/md5_tb_pkg.sv]
// Scoreboard for the md5_message_digest bench: a byte-serial MD5 predictor and a digest word queue.
// Depends on md5_pkg for the item and digest word payload types.
package md5_tb_pkg;
  import md5_pkg::*;

  localparam logic [31:0] CHAIN_START [4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
  };

  localparam logic [31:0] SINE_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // shift per round: row is the round group, column is round mod 4
  localparam int ROT_AMOUNT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  class md5_digest_scoreboard;
    logic [31:0] chain [4];
    logic [31:0] blk [16];
    logic [5:0]  fill;
    logic [63:0] length_bits;
    md5_out_t    expected_words [$];
    int          errors;
    int          words_checked;
    int          messages;

    function new();
      errors = 0;
      words_checked = 0;
      messages = 0;
      restart();
    endfunction

    function void restart();
      chain = CHAIN_START;
      foreach (blk[i]) blk[i] = '0;
      fill = '0;
      length_bits = '0;
    endfunction

    function logic [31:0] rotate_left(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void put_byte(int pos, logic [7:0] v);
      blk[pos / 4][(pos % 4) * 8 +: 8] = v;
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, f, t, sum;
      int g;
      int r;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (r = 0; r < 64; r++) begin
        case (r / 16)
          0: begin
            f = (b & c) | (~b & d);
            g = r;
          end
          1: begin
            f = (b & d) | (c & ~d);
            g = (5 * r + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (3 * r + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * r) % 16;
          end
        endcase
        sum = a + f + SINE_TABLE[r] + blk[g];
        t = d;
        d = c;
        c = b;
        b = b + rotate_left(sum, ROT_AMOUNT[(r / 16) * 4 + r % 4]);
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    // Absorb one accepted item; an end of message queues four digest words.
    function void note_item(md5_in_t it);
      md5_out_t w;
      int p;
      int i;
      if (it.has_byte) begin
        put_byte(fill, it.data_byte);
        length_bits += 64'd8;
        fill++;
        if (fill == 0) compress();
      end
      if (!it.end_of_message) return;
      p = fill;
      put_byte(p, PAD_BYTE);
      for (i = p + 1; i < 64; i++) put_byte(i, 8'h00);
      if (p >= 56) begin
        compress();
        foreach (blk[j]) blk[j] = '0;
      end
      blk[14] = length_bits[31:0];
      blk[15] = length_bits[63:32];
      compress();
      for (i = 0; i < 4; i++) begin
        w.digest_word = chain[i];
        w.word_index  = 2'(i);
        w.last_word   = (i == 3);
        expected_words.push_back(w);
      end
      messages++;
      restart();
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch on digest word %0d, %s: got %h, expected %h",
               $time, words_checked, what, got, want);
      errors++;
    endtask

    task check_word(md5_out_t got);
      md5_out_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        report_mismatch("no digest pending", got.digest_word, 0);
        return;
      end
      want = expected_words.pop_front();
      if (got.digest_word !== want.digest_word)
        report_mismatch("digest_word", got.digest_word, want.digest_word);
      if (got.word_index !== want.word_index)
        report_mismatch("word_index", got.word_index, want.word_index);
      if (got.last_word !== want.last_word)
        report_mismatch("last_word", got.last_word, want.last_word);
    endtask
  endclass

endpackage

[bench/tb_top.sv]
// Top of the md5_message_digest bench: clock, reset, item driver, stalling receiver.
// Depends on md5_pkg, md5_tb_pkg and the md5_message_digest RTL.
module tb_top;
  import md5_pkg::*;
  import md5_tb_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  md5_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  md5_out_t out_data;

  md5_digest_scoreboard sb;

  // calm is raised near the end of the run: no idling on either side after that
  bit calm;
  int items_sent;

  md5_message_digest dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (full stalls, every long block).
  initial begin
    #2000000;
    $display("md5_message_digest test failed");
    $finish;
  end

  // Receiver: hold out_ready low in random bursts, never once calm.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check every accepted digest word against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
  end

  function automatic md5_in_t make_item(bit has, bit fin, logic [7:0] b);
    md5_in_t it;
    it.data_byte      = b;
    it.has_byte       = has;
    it.end_of_message = fin;
    return it;
  endfunction

  // Present one item at the falling edge and hold it until the block takes it.
  task automatic send_item(md5_in_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    if (it.has_byte || it.end_of_message) items_sent++;
    calm = (items_sent >= 180);
  endtask

  // Drop valid to idle the input; n sets the length of the gap.
  task automatic idle_in(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Occasionally idle, and occasionally slip in an item that carries nothing.
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) idle_in($urandom_range(1, 6));
    if ($urandom_range(0, 11) == 0) send_item(make_item(1'b0, 1'b0, 8'($urandom_range(0, 255))));
  endtask

  // Hold the sender until every predicted digest word has been taken.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One message of n_bytes random bytes; the last byte rides on the end item half the time.
  task automatic send_message(int n_bytes);
    bit tail_byte;
    int i;
    tail_byte = (n_bytes > 0) && ($urandom_range(0, 1) == 1);
    for (i = 0; i < n_bytes - tail_byte; i++) begin
      maybe_gap();
      send_item(make_item(1'b1, 1'b0, 8'($urandom_range(0, 255))));
    end
    maybe_gap();
    send_item(make_item(tail_byte, 1'b1, 8'($urandom_range(0, 255))));
  endtask

  initial begin : stimulus
    int long_lo [3];
    int long_hi [3];
    int longs_done;
    int msg;
    int n;

    long_lo = '{52, 56, 64};
    long_hi = '{55, 63, 66};
    longs_done = 0;
    msg = 0;
    sb = new();
    calm = 1'b0;
    items_sent = 0;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: an item with neither byte nor end does nothing
    send_item(make_item(1'b0, 1'b0, 8'hFF));
    // Empty message; the ignored byte field is all ones
    send_item(make_item(1'b0, 1'b1, 8'hFF));
    // One-byte message, the byte carried by the end item itself
    send_item(make_item(1'b1, 1'b1, 8'h00));
    // "abc", a well-known digest
    send_item(make_item(1'b1, 1'b0, 8'h61));
    send_item(make_item(1'b1, 1'b0, 8'h62));
    send_item(make_item(1'b1, 1'b1, 8'h63));
    // Byte extremes with a do-nothing item in the middle, then an empty end item
    send_item(make_item(1'b1, 1'b0, 8'hFF));
    send_item(make_item(1'b0, 1'b0, 8'h00));
    send_item(make_item(1'b1, 1'b0, 8'h00));
    send_item(make_item(1'b0, 1'b1, 8'h00));
    // Second empty message straight after, to see the chaining words restored
    send_item(make_item(1'b0, 1'b1, 8'h5A));
    wait_drained();

    // Random messages: mostly short; every third one, up to three in all, is long:
    // up to the 55-byte padding boundary, across it, or filling a whole block.
    while (items_sent < 200) begin
      if (msg % 3 == 1 && longs_done < 3) begin
        n = $urandom_range(long_lo[longs_done], long_hi[longs_done]);
        longs_done++;
      end else begin
        n = $urandom_range(0, 9);
      end
      send_message(n);
      msg++;
      if (!calm && $urandom_range(0, 7) == 0) wait_drained();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Let any trailing word or stray output show up before judging.
    repeat (100) @(posedge clk);

    $display("Run covered %0d messages from %0d byte or end items, %0d digest words checked.",
             sb.messages, items_sent, sb.words_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("md5_message_digest test passed");
    end else begin
      $display("md5_message_digest test failed");
    end
    $finish;
  end

endmodule
